>>> rtl/tgle_pkg.sv
// ----------------------------------------------------------------------------
// Text glyph layout emitter package
// Shared widths, codes, payload types and helper functions of the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tgle_pkg;

  // Table and fixed-point format.
  localparam int ADVANCE_ENTRIES = 256;
  localparam int FRACTION_BITS   = 16;
  localparam int ADV_ADDR_W      = $clog2(ADVANCE_ENTRIES);

  // Field widths.
  localparam int MODE_W     = 2;
  localparam int CH_W       = 8;
  localparam int POS_W      = 31;
  localparam int ADV_W      = 24;
  localparam int XY_W       = 32;
  localparam int LH_W       = 24;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = ADV_W + 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Input modes.
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X       = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y       = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_MIN_X     = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_MAX_X     = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WRAP_LIMIT_X   = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_LIMIT_Y = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_HEIGHT    = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITEMS      = 4'd7;

  // Character codes.
  localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CH_W-1:0] CH_NL      = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CH_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [CH_W-1:0] CH_LOWER_R = 8'h72;
  localparam logic [CH_W-1:0] CH_TILDE   = 8'h7E;

  // Saturation bound; this value in the wrap register turns wrapping off.
  localparam logic signed [XY_W-1:0] POS_MAX  = 32'sh7FFF_FFFF;
  localparam logic [LH_W-1:0]        LH_RESET = LH_W'(1) << FRACTION_BITS;
  localparam logic [CNT_W-1:0]       MAX_ITEMS_RESET = 16'hFFFF;

  // How one accepted item is handled.
  typedef enum logic [2:0] {
    KIND_LOAD,
    KIND_IGNORE,
    KIND_END,
    KIND_PRINT,
    KIND_NL,
    KIND_CR,
    KIND_TAB,
    KIND_ESC
  } kind_e;

  typedef struct packed {
    logic signed [XY_W-1:0] origin_x;
    logic signed [XY_W-1:0] origin_y;
    logic signed [XY_W-1:0] clip_min_x;
    logic signed [XY_W-1:0] clip_max_x;
    logic signed [XY_W-1:0] wrap_limit_x;
    logic signed [XY_W-1:0] bottom_limit_y;
    logic [LH_W-1:0]        line_height;
    logic [CNT_W-1:0]       max_items;
  } cfg_t;

  // Decoded item: the glyph codes it may draw and its text position.
  typedef struct packed {
    kind_e             kind;
    logic [CH_W-1:0]   g0;
    logic [CH_W-1:0]   g1;
    logic [CH_W-1:0]   g2;
    logic [POS_W-1:0]  pos;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]       text_pos;
    logic [CH_W-1:0]        glyph_code;
    logic                   special_mark;
    logic signed [XY_W-1:0] box_x0;
    logic signed [XY_W-1:0] box_y0;
    logic signed [XY_W-1:0] box_x1;
    logic signed [XY_W-1:0] box_y1;
    logic                   drawn;
    logic [CNT_W-1:0]       items_total;
    logic                   run_end;
  } res_t;

  // Up to three results produced by one item.
  typedef struct packed {
    res_t [2:0] slot;
    logic [1:0] cnt;
  } res_set_t;

  // Saturating add of a non-negative offset to a signed position.
  function automatic logic signed [XY_W-1:0] sat_add(input logic signed [XY_W-1:0] a,
                                                    input logic [SUM_W-1:0] b);
    logic [XY_W+1:0] s;
    s = {{2{a[XY_W-1]}}, a} + {{(XY_W+2-SUM_W){1'b0}}, b};
    if (!s[XY_W+1] && (s[XY_W] || s[XY_W-1])) begin
      return POS_MAX;
    end
    return s[XY_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0, d};
    end
    return CH_UPPER_A - 8'd10 + {4'b0, d};
  endfunction

  // Sort an incoming item and pick the glyph codes it can draw.
  function automatic item_t decode(input logic [MODE_W-1:0] mode,
                                   input logic [CH_W-1:0] ch,
                                   input logic [POS_W-1:0] pos);
    item_t it;
    it.kind = KIND_IGNORE;
    it.g0   = ch;
    it.g1   = ch;
    it.g2   = ch;
    it.pos  = pos;
    case (mode)
      MODE_LOAD: it.kind = KIND_LOAD;
      MODE_END: begin
        it.kind = KIND_END;
        it.g0   = CH_SPACE;
      end
      MODE_CHAR: begin
        if (ch == CH_NL) begin
          it.kind = KIND_NL;
          it.g0   = CH_SPACE;
        end else if (ch == CH_CR) begin
          it.kind = KIND_CR;
          it.g0   = CH_BSLASH;
          it.g1   = CH_LOWER_R;
        end else if (ch == CH_TAB) begin
          it.kind = KIND_TAB;
          it.g0   = CH_SPACE;
        end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
          it.kind = KIND_PRINT;
        end else begin
          it.kind = KIND_ESC;
          it.g0   = CH_BSLASH;
          it.g1   = hex_char(ch[7:4]);
          it.g2   = hex_char(ch[3:0]);
        end
      end
      default: it.kind = KIND_IGNORE;
    endcase
    return it;
  endfunction

  // Number of glyphs an item tries to draw.
  function automatic logic [1:0] glyph_count(input kind_e kind);
    case (kind)
      KIND_END, KIND_PRINT, KIND_NL, KIND_TAB: return 2'd1;
      KIND_CR:  return 2'd2;
      KIND_ESC: return 2'd3;
      default:  return 2'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/tgle_if.sv
// ----------------------------------------------------------------------------
// Text glyph layout emitter channels
// Valid/ready channels for characters, glyph results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Character and table-load channel.
interface tgle_in_if;
  import tgle_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CH_W-1:0]     char_code;
  logic [POS_W-1:0]    char_pos;
  logic [ADV_W-1:0]    advance_value;

  modport source(output valid, mode, char_code, char_pos, advance_value, input ready);
  modport sink(input valid, mode, char_code, char_pos, advance_value, output ready);
endinterface

// Glyph box and count record channel.
interface tgle_out_if;
  import tgle_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [POS_W-1:0]       text_pos;
  logic [CH_W-1:0]        glyph_code;
  logic                   special_mark;
  logic signed [XY_W-1:0] box_x0;
  logic signed [XY_W-1:0] box_y0;
  logic signed [XY_W-1:0] box_x1;
  logic signed [XY_W-1:0] box_y1;
  logic                   drawn;
  logic [CNT_W-1:0]       items_total;
  logic                   run_end;

  modport source(output valid, text_pos, glyph_code, special_mark, box_x0, box_y0,
                 box_x1, box_y1, drawn, items_total, run_end, input ready);
  modport sink(input valid, text_pos, glyph_code, special_mark, box_x0, box_y0,
               box_x1, box_y1, drawn, items_total, run_end, output ready);
endinterface

// Register write channel.
interface tgle_cfg_if;
  import tgle_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source(output valid, addr, wdata, input ready);
  modport sink(input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/tgle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tgle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Storage array.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data registers, held while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tgle_layout.sv
// ----------------------------------------------------------------------------
// Text glyph layout engine
// Holds the pen and frame state and turns one registered item into its
// glyph boxes and count record in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tgle_layout (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   consume_i,
  input  tgle_pkg::cfg_t                         cfg_i,
  input  tgle_pkg::item_t                        item_i,
  input  logic [tgle_pkg::ADV_W-1:0]             adv_w_i,
  input  logic [2:0][tgle_pkg::ADV_W-1:0]        adv_g_i,
  output tgle_pkg::res_set_t                     set_o
);
  import tgle_pkg::*;

  // Frame state.
  logic signed [XY_W-1:0] pen_x_q, pen_x_d;
  logic signed [XY_W-1:0] pen_y_q, pen_y_d;
  logic [CNT_W-1:0]       items_q, items_d;
  logic                   stopped_q, stopped_d;
  logic                   started_q, started_d;

  // Working values.
  logic signed [XY_W-1:0] origin_x, clip_min, clip_max, wrap_lim, bottom;
  logic signed [XY_W-1:0] px0, py0, p, py_w, y_a, y_b, y1, tab_x;
  logic [CNT_W-1:0]       it0;
  logic                   st0, is_char, is_end, wrap, below, run, special, first_ok;
  logic [XY_W+1:0]        wrap_sum;
  logic [1:0]             ng;
  logic [SUM_W-1:0]       sums [3];
  logic signed [XY_W-1:0] x_o [3];
  logic signed [XY_W-1:0] x_p [3];
  logic signed [XY_W-1:0] x_end [3];
  logic signed [XY_W-1:0] x_start [3];
  logic [CH_W-1:0]        codes [3];
  logic [CNT_W-1:0]       cnt;
  logic [1:0]             n, moved;
  logic                   blocked;

  assign origin_x = cfg_i.origin_x;
  assign clip_min = cfg_i.clip_min_x;
  assign clip_max = cfg_i.clip_max_x;
  assign wrap_lim = cfg_i.wrap_limit_x;
  assign bottom   = cfg_i.bottom_limit_y;

  assign codes[0] = item_i.g0;
  assign codes[1] = item_i.g1;
  assign codes[2] = item_i.g2;

  // Effective state: a frame that has not started begins at the origin.
  always_comb begin
    px0 = started_q ? pen_x_q : origin_x;
    py0 = started_q ? pen_y_q : cfg_i.origin_y;
    it0 = started_q ? items_q : '0;
    st0 = started_q & stopped_q;
    is_end  = (item_i.kind == KIND_END);
    is_char = (item_i.kind == KIND_PRINT) || (item_i.kind == KIND_NL) ||
              (item_i.kind == KIND_CR) || (item_i.kind == KIND_TAB) ||
              (item_i.kind == KIND_ESC);
    special = (item_i.kind == KIND_CR) || (item_i.kind == KIND_ESC);
    ng      = glyph_count(item_i.kind);
  end

  // Wrap test and line positions.
  always_comb begin
    wrap_sum = {{2{px0[XY_W-1]}}, px0} + {{(XY_W+2-ADV_W){1'b0}}, adv_w_i};
    wrap = is_char && !st0 && (item_i.kind != KIND_NL) && (wrap_lim != POS_MAX) &&
           ($signed(wrap_sum) > $signed({{2{wrap_lim[XY_W-1]}}, wrap_lim}));
    y_a  = sat_add(py0, SUM_W'(cfg_i.line_height));
    y_b  = sat_add(py0, SUM_W'({cfg_i.line_height, 1'b0}));
    py_w = wrap ? y_a : py0;
    y1   = wrap ? y_b : y_a;
    p    = wrap ? origin_x : px0;
    below = py_w > bottom;
  end

  // Pen positions after each glyph, from both possible line starts.
  always_comb begin
    sums[0] = SUM_W'(adv_g_i[0]);
    sums[1] = SUM_W'(adv_g_i[0]) + SUM_W'(adv_g_i[1]);
    sums[2] = SUM_W'(adv_g_i[0]) + SUM_W'(adv_g_i[1]) + SUM_W'(adv_g_i[2]);
    for (int k = 0; k < 3; k++) begin
      x_o[k]   = sat_add(origin_x, sums[k]);
      x_p[k]   = sat_add(px0, sums[k]);
      x_end[k] = wrap ? x_o[k] : x_p[k];
    end
    x_start[0] = p;
    x_start[1] = x_end[0];
    x_start[2] = x_end[1];
    tab_x = wrap ? sat_add(origin_x, SUM_W'(adv_w_i)) : sat_add(px0, SUM_W'(adv_w_i));
  end

  // Glyph emission with item cap and horizontal clip, then the count record.
  always_comb begin
    run = is_char ? (!st0 && !below) : (is_end && (!below || (it0 == '0)));
    first_ok = run && (it0 < cfg_i.max_items);
    set_o   = '0;
    cnt     = it0;
    n       = 2'd0;
    moved   = 2'd0;
    blocked = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (run && (2'(k) < ng) && !blocked) begin
        if (cnt >= cfg_i.max_items) begin
          blocked = 1'b1;
        end else begin
          moved = 2'(k + 1);
          if ((x_start[k] <= clip_max) && (x_end[k] >= clip_min)) begin
            cnt = cnt + 16'd1;
            set_o.slot[n].text_pos     = item_i.pos;
            set_o.slot[n].glyph_code   = codes[k];
            set_o.slot[n].special_mark = special;
            set_o.slot[n].box_x0       = x_start[k];
            set_o.slot[n].box_y0       = py_w;
            set_o.slot[n].box_x1       = x_end[k];
            set_o.slot[n].box_y1       = y1;
            set_o.slot[n].drawn        = 1'b1;
            set_o.slot[n].items_total  = cnt;
            n = n + 2'd1;
          end
        end
      end
    end
    if (is_end) begin
      set_o.slot[n].items_total = cnt;
      n = n + 2'd1;
    end
    if (n != 2'd0) begin
      set_o.slot[n - 2'd1].run_end = 1'b1;
    end
    set_o.cnt = n;
  end

  // Next frame state.
  always_comb begin
    case (item_i.kind)
      KIND_NL:  pen_x_d = first_ok ? origin_x : p;
      KIND_TAB: pen_x_d = first_ok ? tab_x : p;
      default:  pen_x_d = (moved == 2'd0) ? p : x_end[moved - 2'd1];
    endcase
    pen_y_d   = ((item_i.kind == KIND_NL) && first_ok) ? y1 : py_w;
    items_d   = cnt;
    stopped_d = is_char ? (st0 || (pen_y_d > bottom)) : st0;
    started_d = is_char;
  end

  // State registers; loads and unused modes leave them untouched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      items_q   <= '0;
      stopped_q <= 1'b0;
      started_q <= 1'b0;
    end else if (consume_i && (is_char || is_end)) begin
      pen_x_q   <= pen_x_d;
      pen_y_q   <= pen_y_d;
      items_q   <= items_d;
      stopped_q <= stopped_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tgle_result_buf.sv
// ----------------------------------------------------------------------------
// Text glyph layout result buffer
// Holds the results of one item and hands them out one transaction a cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tgle_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tgle_pkg::res_set_t set_i,
  output logic               free_o,
  tgle_out_if.source         out_o
);
  import tgle_pkg::*;

  res_t [2:0] slot_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       fire, last;
  res_t       cur;

  assign fire   = out_o.valid && out_o.ready;
  assign last   = (idx_q == (cnt_q - 2'd1));
  assign free_o = (cnt_q == 2'd0) || (fire && last);

  // Slot pointer and fill count.
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = set_i.cnt;
      idx_d = 2'd0;
    end else if (fire) begin
      if (last) begin
        cnt_d = 2'd0;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= set_i.slot;
    end
  end

  // Present the current slot.
  assign cur                = slot_q[idx_q];
  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.text_pos     = cur.text_pos;
  assign out_o.glyph_code   = cur.glyph_code;
  assign out_o.special_mark = cur.special_mark;
  assign out_o.box_x0       = cur.box_x0;
  assign out_o.box_y0       = cur.box_y0;
  assign out_o.box_x1       = cur.box_x1;
  assign out_o.box_y1       = cur.box_y1;
  assign out_o.drawn        = cur.drawn;
  assign out_o.items_total  = cur.items_total;
  assign out_o.run_end      = cur.run_end;

endmodule

`default_nettype wire

>>> rtl/text_glyph_layout_emitter.sv
// ----------------------------------------------------------------------------
// Text glyph layout emitter
// Lays out text bytes as clipped, wrapped glyph boxes in Q16.16 fixed point,
// using an advance-width table loaded through the input channel.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register until the buffer is free.
// Throughput: one item per cycle while the output is ready and each item
// yields at most one result; more results (up to 3) hold the result buffer.
// Reset clears the registers, the frame state and the channel control; the
// advance table is undefined until loaded and is never swept.
`default_nettype none

module text_glyph_layout_emitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgle_cfg_if.sink   cfg_i,
  tgle_in_if.sink    in_i,
  tgle_out_if.source out_o
);
  import tgle_pkg::*;

  cfg_t                  cfg_q, cfg_d;
  logic                  s1_valid_q;
  item_t                 s1_item_q;
  item_t                 dec_item;
  logic                  in_accept, s1_consume, buf_free, out_fire;
  logic [ADV_W-1:0]      adv_w, adv_g0, adv_g1, adv_g2;
  res_set_t              res_set;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.addr)
        REG_ORIGIN_X:       cfg_d.origin_x       = cfg_i.wdata;
        REG_ORIGIN_Y:       cfg_d.origin_y       = cfg_i.wdata;
        REG_CLIP_MIN_X:     cfg_d.clip_min_x     = cfg_i.wdata;
        REG_CLIP_MAX_X:     cfg_d.clip_max_x     = cfg_i.wdata;
        REG_WRAP_LIMIT_X:   cfg_d.wrap_limit_x   = cfg_i.wdata;
        REG_BOTTOM_LIMIT_Y: cfg_d.bottom_limit_y = cfg_i.wdata;
        REG_LINE_HEIGHT:    cfg_d.line_height    = cfg_i.wdata[LH_W-1:0];
        REG_MAX_ITEMS:      cfg_d.max_items      = cfg_i.wdata[CNT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x       <= '0;
      cfg_q.origin_y       <= '0;
      cfg_q.clip_min_x     <= '0;
      cfg_q.clip_max_x     <= POS_MAX;
      cfg_q.wrap_limit_x   <= POS_MAX;
      cfg_q.bottom_limit_y <= POS_MAX;
      cfg_q.line_height    <= LH_RESET;
      cfg_q.max_items      <= MAX_ITEMS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register; it moves on when the result buffer can take its results.
  assign dec_item   = decode(in_i.mode, in_i.char_code, in_i.char_pos);
  assign s1_consume = s1_valid_q && buf_free;
  assign in_i.ready = !s1_valid_q || s1_consume;
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= dec_item;
    end
  end

  // Advance table, two copies so that four entries are read per item.
  tgle_ram #(
    .WIDTH(ADV_W),
    .DEPTH(ADVANCE_ENTRIES)
  ) u_adv_ram_a (
    .clk_i    (clk_i),
    .we_i     (in_accept && (in_i.mode == MODE_LOAD)),
    .waddr_i  (in_i.char_code[ADV_ADDR_W-1:0]),
    .wdata_i  (in_i.advance_value),
    .re_i     (in_accept),
    .raddr0_i (in_i.char_code[ADV_ADDR_W-1:0]),
    .raddr1_i (dec_item.g0[ADV_ADDR_W-1:0]),
    .rdata0_o (adv_w),
    .rdata1_o (adv_g0)
  );

  tgle_ram #(
    .WIDTH(ADV_W),
    .DEPTH(ADVANCE_ENTRIES)
  ) u_adv_ram_b (
    .clk_i    (clk_i),
    .we_i     (in_accept && (in_i.mode == MODE_LOAD)),
    .waddr_i  (in_i.char_code[ADV_ADDR_W-1:0]),
    .wdata_i  (in_i.advance_value),
    .re_i     (in_accept),
    .raddr0_i (dec_item.g1[ADV_ADDR_W-1:0]),
    .raddr1_i (dec_item.g2[ADV_ADDR_W-1:0]),
    .rdata0_o (adv_g1),
    .rdata1_o (adv_g2)
  );

  // Layout of the registered item.
  tgle_layout u_layout (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .consume_i (s1_consume),
    .cfg_i     (cfg_q),
    .item_i    (s1_item_q),
    .adv_w_i   (adv_w),
    .adv_g_i   ({adv_g2, adv_g1, adv_g0}),
    .set_o     (res_set)
  );

  // Result register and output sequencing.
  tgle_result_buf u_result_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_consume),
    .set_i  (res_set),
    .free_o (buf_free),
    .out_o  (out_o)
  );

`ifndef NO_ASSERTIONS
  // The last result of an item leaves the output empty unless a new item loads.
  a_run_end_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.run_end && !s1_consume) |=> !out_o.valid)
    else $error("output still valid after the last result of an item");

  // The count record always closes its item.
  a_record_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.drawn) |-> out_o.run_end)
    else $error("count record is not the last result of its item");

  // A drawn glyph is always counted.
  a_glyph_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.drawn) |-> (out_o.items_total != '0))
    else $error("glyph result carries a zero item count");

  // A held item stays in the input register until the buffer takes it.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_consume) |=> s1_valid_q)
    else $error("input register lost an item");
`endif

endmodule

`default_nettype wire
